FILE: rtl/mrne_pkg.sv
`timescale 1ns / 1ps
// mrne_pkg: shared widths, round-kind codes and the flag struct for the
// mantissa round-to-nearest-even pipeline. No dependencies.
package mrne_pkg;

    localparam int LEN_W  = 7;   // mant_len and target_len width
    localparam int EXP_W  = 16;  // signed exponent width
    localparam int KIND_W = 2;   // round_kind width

    localparam logic [LEN_W-1:0]        TARGET_LEN_RST = 7'd53;
    localparam logic signed [EXP_W-1:0] EXP_MAX        = 16'sh7FFF;

    typedef enum logic [KIND_W-1:0] {
        RK_NONE = 2'd0,  // exact or no rounding
        RK_UP   = 2'd1,  // rounded up
        RK_DOWN = 2'd2   // dropped bits nonzero, truncated
    } t_round_kind;

    // rounding decision handed from the decide stage to the increment stage
    typedef struct packed {
        logic round_up;
        logic inexact;
    } t_rnd_flags;

endpackage

FILE: rtl/mrne_mask.sv
`timescale 1ns / 1ps
// mrne_mask: pipeline stage 1, clamps the lengths, strips invalid low bits
// and builds the keep mask. Depends on mrne_pkg.
module mrne_mask #(
    parameter int MANT_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [mrne_pkg::LEN_W-1:0]         i_target_len,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [MANT_BITS-1:0]               i_mant,
    input  logic [mrne_pkg::LEN_W-1:0]         i_len,
    input  logic signed [mrne_pkg::EXP_W-1:0]  i_exp,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [MANT_BITS-1:0]               o_mant,
    output logic [MANT_BITS-1:0]               o_keep,
    output logic                               o_need_round,
    output logic signed [mrne_pkg::EXP_W-1:0]  o_exp
);

    localparam logic [mrne_pkg::LEN_W-1:0] LEN_MAX = mrne_pkg::LEN_W'(MANT_BITS);
    localparam logic [MANT_BITS-1:0]       ONES    = {MANT_BITS{1'b1}};

    logic [mrne_pkg::LEN_W-1:0] len_c;
    logic [mrne_pkg::LEN_W-1:0] tgt_sat;
    logic [mrne_pkg::LEN_W-1:0] tgt_c;

    logic                              r_valid;
    logic [MANT_BITS-1:0]              r_mant;
    logic [MANT_BITS-1:0]              r_keep;
    logic                              r_need;
    logic signed [mrne_pkg::EXP_W-1:0] r_exp;

    always_comb begin
        len_c   = (i_len > LEN_MAX) ? LEN_MAX : i_len;
        tgt_sat = (i_target_len > LEN_MAX) ? LEN_MAX : i_target_len;
        // zero target behaves as one bit
        tgt_c   = (tgt_sat == '0) ? mrne_pkg::LEN_W'(1) : tgt_sat;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mant <= i_mant & ~(ONES >> len_c);
            r_keep <= ~(ONES >> tgt_c);
            r_need <= (len_c > tgt_c);
            r_exp  <= i_exp;
        end
    end

    assign o_valid      = r_valid;
    assign o_mant       = r_mant;
    assign o_keep       = r_keep;
    assign o_need_round = r_need;
    assign o_exp        = r_exp;

endmodule

FILE: rtl/mrne_decide.sv
`timescale 1ns / 1ps
// mrne_decide: pipeline stage 2, extracts guard, sticky and kept LSB and
// decides round up or truncate. Depends on mrne_pkg.
module mrne_decide #(
    parameter int MANT_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [MANT_BITS-1:0]               i_mant,
    input  logic [MANT_BITS-1:0]               i_keep,
    input  logic                               i_need_round,
    input  logic signed [mrne_pkg::EXP_W-1:0]  i_exp,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [MANT_BITS-1:0]               o_kept,
    output logic [MANT_BITS-1:0]               o_keep,
    output logic [MANT_BITS-1:0]               o_lsb_mask,
    output mrne_pkg::t_rnd_flags               o_flags,
    output logic signed [mrne_pkg::EXP_W-1:0]  o_exp
);

    logic [MANT_BITS-1:0] guard_mask;
    logic [MANT_BITS-1:0] lsb_mask;
    logic [MANT_BITS-1:0] dropped;
    logic                 guard;
    logic                 sticky;
    logic                 lsb;
    mrne_pkg::t_rnd_flags n_flags;

    logic                              r_valid;
    logic [MANT_BITS-1:0]              r_kept;
    logic [MANT_BITS-1:0]              r_keep;
    logic [MANT_BITS-1:0]              r_lsb_mask;
    mrne_pkg::t_rnd_flags              r_flags;
    logic signed [mrne_pkg::EXP_W-1:0] r_exp;

    always_comb begin
        // first dropped position and last kept position
        guard_mask = {1'b1, i_keep[MANT_BITS-1:1]} & ~i_keep;
        lsb_mask   = i_keep & ~{i_keep[MANT_BITS-2:0], 1'b0};
        dropped    = i_mant & ~i_keep;
        guard      = |(i_mant & guard_mask);
        sticky     = |(dropped & ~guard_mask);
        lsb        = |(i_mant & lsb_mask);
        n_flags.round_up = i_need_round && guard && (sticky || lsb);
        n_flags.inexact  = i_need_round && (|dropped) && !n_flags.round_up;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kept     <= i_mant & i_keep;
            r_keep     <= i_keep;
            r_lsb_mask <= lsb_mask;
            r_flags    <= n_flags;
            r_exp      <= i_exp;
        end
    end

    assign o_valid    = r_valid;
    assign o_kept     = r_kept;
    assign o_keep     = r_keep;
    assign o_lsb_mask = r_lsb_mask;
    assign o_flags    = r_flags;
    assign o_exp      = r_exp;

endmodule

FILE: rtl/mrne_incr.sv
`timescale 1ns / 1ps
// mrne_incr: pipeline stage 3, the mantissa increment, carry renormalize and
// saturating exponent bump; holds the output register. Depends on mrne_pkg.
module mrne_incr #(
    parameter int MANT_BITS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [MANT_BITS-1:0]               i_kept,
    input  logic [MANT_BITS-1:0]               i_keep,
    input  logic [MANT_BITS-1:0]               i_lsb_mask,
    input  mrne_pkg::t_rnd_flags               i_flags,
    input  logic signed [mrne_pkg::EXP_W-1:0]  i_exp,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [MANT_BITS-1:0]               o_mant,
    output logic signed [mrne_pkg::EXP_W-1:0]  o_exp,
    output mrne_pkg::t_round_kind              o_kind
);

    logic [MANT_BITS:0]                sum;
    logic [MANT_BITS-1:0]              n_mant;
    logic signed [mrne_pkg::EXP_W-1:0] n_exp;
    mrne_pkg::t_round_kind             n_kind;

    logic                              r_valid;
    logic [MANT_BITS-1:0]              r_mant;
    logic signed [mrne_pkg::EXP_W-1:0] r_exp;
    mrne_pkg::t_round_kind             r_kind;

    always_comb begin
        sum    = {1'b0, i_kept} + {1'b0, i_lsb_mask};
        n_mant = i_kept;
        n_exp  = i_exp;
        n_kind = mrne_pkg::RK_NONE;
        if (i_flags.round_up) begin
            n_kind = mrne_pkg::RK_UP;
            if (sum[MANT_BITS]) begin
                // carry out: shift right with a leading one
                n_mant = {1'b1, sum[MANT_BITS-1:1]} & i_keep;
                if (i_exp != mrne_pkg::EXP_MAX) begin
                    n_exp = i_exp + mrne_pkg::EXP_W'(1);
                end
            end else begin
                n_mant = sum[MANT_BITS-1:0] & i_keep;
            end
        end else if (i_flags.inexact) begin
            n_kind = mrne_pkg::RK_DOWN;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mant <= n_mant;
            r_exp  <= n_exp;
            r_kind <= n_kind;
        end
    end

    assign o_valid = r_valid;
    assign o_mant  = r_mant;
    assign o_exp   = r_exp;
    assign o_kind  = r_kind;

endmodule

FILE: rtl/mantissa_round_nearest_even.sv
`timescale 1ns / 1ps
// mantissa_round_nearest_even: top level of the mantissa rounding pipeline.
// Depends on mrne_pkg, mrne_mask, mrne_decide and mrne_incr.
//
// Usage:
//   A left-aligned mantissa with its valid length and exponent enters on the
//   s_axis stream; the mantissa rounded to target_len bits (round to nearest,
//   ties to even), the exponent and the round kind leave on m_axis.
//   target_len is written on the cfg channel (i_cfg_valid/o_cfg_ready/
//   i_cfg_data), always ready; write it only while no transaction is in
//   flight. It resets to 53.
// Pipeline: three register stages; an accepted input transaction passes the
//   mask, decide and increment registers in turn, and m_axis_tvalid rises
//   when the increment register holds its result.
// Throughput: one transaction per cycle while m_axis_tready is high. Three
//   register stages (mask build, guard/sticky decision, 64-bit increment)
//   each carry a valid bit, and each stage refills as soon as the one after
//   it moves, so bubbles are squeezed out.
// Stall: when m_axis_tready is low the output holds; stages behind it keep
//   filling, and s_axis_tready drops only once all three stages are full.
// Reset (i_rst_n, synchronous, active low) empties the pipeline and loads
//   the default target length.
module mantissa_round_nearest_even #(
    parameter  int MANT_BITS = 64,
    // stream widths: fields packed from bit 0, padded to whole bytes
    localparam int IN_W  = ((MANT_BITS + mrne_pkg::LEN_W + mrne_pkg::EXP_W + 7) / 8) * 8,
    localparam int OUT_W = ((MANT_BITS + mrne_pkg::EXP_W + mrne_pkg::KIND_W + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: target_len
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mrne_pkg::LEN_W-1:0]    i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata from bit 0: mantissa_in, mant_len, exponent_in, zero pad
    input  logic [IN_W-1:0]               s_axis_tdata,
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata from bit 0: mantissa_out, exponent_out, round_kind, zero pad
    output logic [OUT_W-1:0]              m_axis_tdata
);

    localparam logic [mrne_pkg::LEN_W-1:0] LEN_MAX = mrne_pkg::LEN_W'(MANT_BITS);

    // configuration register
    logic [mrne_pkg::LEN_W-1:0] r_target_len;

    // input field slices
    logic [MANT_BITS-1:0]              in_mant;
    logic [mrne_pkg::LEN_W-1:0]        in_len;
    logic signed [mrne_pkg::EXP_W-1:0] in_exp;

    // stage 1 -> 2
    logic                              s1_valid;
    logic                              s1_ready;
    logic [MANT_BITS-1:0]              s1_mant;
    logic [MANT_BITS-1:0]              s1_keep;
    logic                              s1_need;
    logic signed [mrne_pkg::EXP_W-1:0] s1_exp;

    // stage 2 -> 3
    logic                              s2_valid;
    logic                              s2_ready;
    logic [MANT_BITS-1:0]              s2_kept;
    logic [MANT_BITS-1:0]              s2_keep;
    logic [MANT_BITS-1:0]              s2_lsb_mask;
    mrne_pkg::t_rnd_flags              s2_flags;
    logic signed [mrne_pkg::EXP_W-1:0] s2_exp;

    // stage 3 outputs
    logic [MANT_BITS-1:0]              out_mant;
    logic signed [mrne_pkg::EXP_W-1:0] out_exp;
    mrne_pkg::t_round_kind             out_kind;

    // keep mask of the current target, for the output check
    logic [mrne_pkg::LEN_W-1:0] chk_tgt;
    logic [MANT_BITS-1:0]       chk_keep;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_len <= mrne_pkg::TARGET_LEN_RST;
        end else if (i_cfg_valid) begin
            r_target_len <= i_cfg_data;
        end
    end

    assign in_mant = s_axis_tdata[MANT_BITS-1:0];
    assign in_len  = s_axis_tdata[MANT_BITS +: mrne_pkg::LEN_W];
    assign in_exp  = s_axis_tdata[MANT_BITS + mrne_pkg::LEN_W +: mrne_pkg::EXP_W];

    mrne_mask #(
        .MANT_BITS (MANT_BITS)
    ) u_mask (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_target_len (r_target_len),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_mant       (in_mant),
        .i_len        (in_len),
        .i_exp        (in_exp),
        .o_valid      (s1_valid),
        .i_ready      (s1_ready),
        .o_mant       (s1_mant),
        .o_keep       (s1_keep),
        .o_need_round (s1_need),
        .o_exp        (s1_exp)
    );

    mrne_decide #(
        .MANT_BITS (MANT_BITS)
    ) u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s1_valid),
        .o_ready      (s1_ready),
        .i_mant       (s1_mant),
        .i_keep       (s1_keep),
        .i_need_round (s1_need),
        .i_exp        (s1_exp),
        .o_valid      (s2_valid),
        .i_ready      (s2_ready),
        .o_kept       (s2_kept),
        .o_keep       (s2_keep),
        .o_lsb_mask   (s2_lsb_mask),
        .o_flags      (s2_flags),
        .o_exp        (s2_exp)
    );

    mrne_incr #(
        .MANT_BITS (MANT_BITS)
    ) u_incr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s2_valid),
        .o_ready    (s2_ready),
        .i_kept     (s2_kept),
        .i_keep     (s2_keep),
        .i_lsb_mask (s2_lsb_mask),
        .i_flags    (s2_flags),
        .i_exp      (s2_exp),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_mant     (out_mant),
        .o_exp      (out_exp),
        .o_kind     (out_kind)
    );

    assign m_axis_tdata = OUT_W'({out_kind, out_exp, out_mant});

    always_comb begin
        chk_tgt  = (r_target_len > LEN_MAX) ? LEN_MAX : r_target_len;
        chk_tgt  = (chk_tgt == '0) ? mrne_pkg::LEN_W'(1) : chk_tgt;
        chk_keep = ~({MANT_BITS{1'b1}} >> chk_tgt);
    end

    // ready drops only with every stage occupied
    a_no_bubble_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (s1_valid && s2_valid && m_axis_tvalid))
        else $error("input stalled while the pipeline has a free stage");

    // pipeline empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!m_axis_tvalid && !s1_valid && !s2_valid))
        else $error("pipeline not empty after reset");

    // a transaction cannot be both rounded up and truncated
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid |-> !(s2_flags.round_up && s2_flags.inexact))
        else $error("round-up and inexact both set");

    // bits below the target length are always cleared
    a_low_bits_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((out_mant & ~chk_keep) == '0))
        else $error("mantissa bits below target length not cleared");

endmodule

FILE: tb/sv/mantissa_round_nearest_even_tb.sv
`timescale 1ns / 1ps
// mantissa_round_nearest_even_tb: self-checking testbench for the mantissa
// round-to-nearest-even block. Depends on mrne_pkg and mantissa_round_nearest_even.
module mantissa_round_nearest_even_tb;

    localparam int LEN_W       = mrne_pkg::LEN_W;
    // stream widths: fields packed from bit 0, padded to whole bytes
    localparam int TDATA_IN_W  = 88;  // 64 mantissa + 7 length + 16 exponent + pad
    localparam int TDATA_OUT_W = 88;  // 64 mantissa + 16 exponent + 2 kind + pad
    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 200;
    localparam int MAX_REPORTS = 30;

    typedef struct {
        logic [63:0]           mant;
        logic signed [15:0]    exp;
        mrne_pkg::t_round_kind kind;
    } t_rounded;

    // directed stimulus row; when known is set the expected result is typed in
    typedef struct {
        logic [LEN_W-1:0]   tgt;
        logic [63:0]        mant;
        logic [LEN_W-1:0]   len;
        logic signed [15:0] exp;
        bit                 known;
        t_rounded           want;
    } t_dir_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [LEN_W-1:0]       i_cfg_data = mrne_pkg::TARGET_LEN_RST;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata from bit 0: mantissa_in, mant_len, exponent_in, zero pad
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata from bit 0: mantissa_out, exponent_out, round_kind, zero pad
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    mantissa_round_nearest_even dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_rounded         pending_q[$];     // expected results, oldest first
    t_dir_row         dir_rows[$];
    logic [LEN_W-1:0] cur_tgt = mrne_pkg::TARGET_LEN_RST;  // mirror of target_len
    int               errors = 0;
    int               items_sent = 0;
    int               results_seen = 0;
    int               cfg_writes = 0;
    int               cycles = 0;
    int               burst_left = 0;
    bit               calm = 1'b0;      // sender runs without gaps
    int               stall_mode = 0;
    int               stall_left = 0;

    // ones in the top k bits of a left-aligned mantissa
    function automatic logic [63:0] top_ones(input int unsigned k);
        if (k == 0)
            return 64'd0;
        if (k >= 64)
            return ~64'd0;
        return ~64'd0 << (64 - k);
    endfunction

    // effective target length: saturate at 64, zero acts as one
    function automatic int unsigned eff_target(input logic [LEN_W-1:0] tgt);
        int unsigned t;
        t = (tgt > 7'd64) ? 32'd64 : 32'(tgt);
        return (t == 0) ? 1 : t;
    endfunction

    // predicted rounding of one number to the current target length
    function automatic t_rounded round_nearest_even(input logic [63:0] mant_raw,
                                                     input logic [LEN_W-1:0] len_raw,
                                                     input logic signed [15:0] exp_in,
                                                     input logic [LEN_W-1:0] tgt_raw);
        int unsigned len;
        int unsigned tgt;
        logic [63:0] mant;
        logic [63:0] keep;
        logic [63:0] kept;
        logic [63:0] dropped;
        logic [63:0] guard_bit;
        logic [63:0] lsb_bit;
        logic [63:0] sum;
        logic        carry;
        t_rounded    r;
        len    = (len_raw > 7'd64) ? 32'd64 : 32'(len_raw);
        tgt    = eff_target(tgt_raw);
        mant   = mant_raw & top_ones(len);
        r.exp  = exp_in;
        r.kind = mrne_pkg::RK_NONE;
        r.mant = mant;
        if (len > tgt) begin
            // len > tgt keeps tgt at 63 or less, so both shifts are in range
            keep      = top_ones(tgt);
            kept      = mant & keep;
            dropped   = mant & ~keep;
            guard_bit = 64'd1 << (63 - tgt);
            lsb_bit   = 64'd1 << (64 - tgt);
            if ((mant & guard_bit) != 0 &&
                ((dropped & ~guard_bit) != 0 || (kept & lsb_bit) != 0)) begin
                {carry, sum} = {1'b0, kept} + {1'b0, lsb_bit};
                r.kind = mrne_pkg::RK_UP;
                if (carry) begin
                    sum = {1'b1, sum[63:1]};
                    if (r.exp != mrne_pkg::EXP_MAX)
                        r.exp = r.exp + 16'sd1;
                end
                r.mant = sum & keep;
            end else begin
                r.mant = kept;
                if (dropped != 0)
                    r.kind = mrne_pkg::RK_DOWN;
            end
        end
        return r;
    endfunction

    function automatic void add_row(input logic [LEN_W-1:0] tgt, input logic [63:0] mant,
                                    input logic [LEN_W-1:0] len, input int exp,
                                    input bit known, input logic [63:0] w_mant,
                                    input int w_exp, input mrne_pkg::t_round_kind w_kind);
        t_dir_row row;
        row.tgt       = tgt;
        row.mant      = mant;
        row.len       = len;
        row.exp       = 16'(exp);
        row.known     = known;
        row.want.mant = w_mant;
        row.want.exp  = 16'(w_exp);
        row.want.kind = w_kind;
        dir_rows.push_back(row);
    endfunction

    // Drive one input transaction; called right after a rising edge, returns
    // right after the edge that accepted it. Bursts of random length with
    // random gaps in between, unless the phase runs calm.
    task automatic send_item(input logic [63:0] mant, input logic [LEN_W-1:0] len,
                             input logic signed [15:0] exp, input t_rounded want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tdata  <= {1'b0, exp, len, mant};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_q.push_back(want);
        items_sent++;
    endtask

    // Let the pipeline empty, then write target_len on the config channel.
    task automatic set_target(input logic [LEN_W-1:0] tgt);
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
        i_cfg_data  <= tgt;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_tgt = tgt;
        cfg_writes++;
    endtask

    // Random number shaped around the rounding point of the target length.
    task automatic make_item(output logic [63:0] mant, output logic [LEN_W-1:0] len,
                             output logic signed [15:0] exp);
        int unsigned te;
        int          pick;
        logic [63:0] noise;
        logic [63:0] guard_bit;
        te    = eff_target(cur_tgt);
        pick  = $urandom_range(0, 9);
        mant  = {$urandom, $urandom};
        noise = {$urandom, $urandom};
        exp   = 16'($urandom);
        case ($urandom_range(0, 7))
            0: exp = mrne_pkg::EXP_MAX;
            1: exp = 16'sh8000;
            default: ;
        endcase
        if (te == 64 && pick != 7)
            pick = 6;
        guard_bit = (te < 64) ? (64'd1 << (63 - te)) : 64'd0;
        case (pick)
            // ordinary: longer than the target, random bits
            0, 1, 2, 3: len = 7'($urandom_range(te + 1, 64));
            // exact tie, with junk below the valid length half the time
            4: begin
                len  = 7'($urandom_range(te + 1, 64));
                mant = (mant & top_ones(te)) | guard_bit;
                if ($urandom_range(0, 1))
                    mant = mant | (noise & ~top_ones(len));
            end
            // kept part all ones: carry out and renormalize
            5, 9: begin
                len  = 7'($urandom_range(te + 1, 64));
                mant = top_ones(te) | guard_bit | (noise & ~top_ones(te + 1));
                if (pick == 9)
                    exp = ($urandom_range(0, 1)) ? mrne_pkg::EXP_MAX : exp;
            end
            // any length the field allows, beyond 64 too
            6: len = 7'($urandom_range(0, 127));
            // shorter than or equal to the target: padding only
            7: len = 7'($urandom_range(0, te));
            // guard set, a single sticky bit at the bottom of the valid part when it reaches below the guard
            default: begin
                len  = 7'($urandom_range(te + 1, 64));
                mant = (mant & top_ones(te)) | guard_bit;
                if (len > te + 1)
                    mant = mant | (64'd1 << (64 - len));
            end
        endcase
    endtask

    // Result check and receiver stall pattern. Inputs are sampled at the edge
    // before any nonblocking update lands.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("result transaction with none expected: tdata %h", m_axis_tdata);
            end else begin
                automatic t_rounded want = pending_q.pop_front();
                if (m_axis_tdata[63:0] !== want.mant) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $error("mantissa_out: expected %h, got %h",
                               want.mant, m_axis_tdata[63:0]);
                end
                if (m_axis_tdata[79:64] !== want.exp) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $error("exponent_out: expected %0d, got %0d",
                               want.exp, $signed(m_axis_tdata[79:64]));
                end
                if (m_axis_tdata[81:80] !== want.kind) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $error("round_kind: expected %0d, got %0d",
                               want.kind, m_axis_tdata[81:80]);
                end
            end
        end
        // receiver: modes of random length, from always ready to mostly stalled
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 128);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= (cycles % 5 != 0);
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("mantissa_round_nearest_even_tb: done, errors");
            $finish;
        end
    end

    initial begin
        logic [63:0]        mant;
        logic [LEN_W-1:0]   len;
        logic signed [15:0] exp;
        logic [LEN_W-1:0]   phase_tgt [N_PHASES];
        t_rounded           want;

        // directed rows; a target of 0 acts as 1 and 127 saturates to 64
        // zero-length mantissa
        add_row(7'd53, ~64'd0, 7'd0, 0, 1, 64'd0, 0, mrne_pkg::RK_NONE);
        // exact fit, nothing dropped
        add_row(7'd53, ~64'd0, 7'd53, 5, 1, 64'hFFFF_FFFF_FFFF_F800, 5,
                mrne_pkg::RK_NONE);
        // carry with the exponent at its maximum
        add_row(7'd53, ~64'd0, 7'd64, 32767, 1, 64'h8000_0000_0000_0000, 32767,
                mrne_pkg::RK_UP);
        // length above 64, carry from the most negative exponent
        add_row(7'd53, ~64'd0, 7'd127, -32768, 1, 64'h8000_0000_0000_0000, -32767,
                mrne_pkg::RK_UP);
        // tie with even LSB stays, still reported as rounded down
        add_row(7'd53, 64'h8000_0000_0000_0400, 7'd64, 1, 1,
                64'h8000_0000_0000_0000, 1, mrne_pkg::RK_DOWN);
        // tie with odd LSB rounds up
        add_row(7'd53, 64'h8000_0000_0000_0C00, 7'd64, 1, 1,
                64'h8000_0000_0000_1000, 1, mrne_pkg::RK_UP);
        // guard plus sticky rounds up
        add_row(7'd53, 64'h8000_0000_0000_0401, 7'd64, 2, 1,
                64'h8000_0000_0000_0800, 2, mrne_pkg::RK_UP);
        // sticky bit lies below the valid length, so it is a tie
        add_row(7'd53, 64'h8000_0000_0000_0401, 7'd54, 2, 1,
                64'h8000_0000_0000_0000, 2, mrne_pkg::RK_DOWN);
        // below half
        add_row(7'd53, 64'h8000_0000_0000_03FF, 7'd64, 3, 1,
                64'h8000_0000_0000_0000, 3, mrne_pkg::RK_DOWN);
        add_row(7'd53, 64'd0, 7'd64, -1, 1, 64'd0, -1, mrne_pkg::RK_NONE);
        add_row(7'd53, 64'h0123_4567_89AB_CDEF, 7'd60, 1234, 0, '0, 0,
                mrne_pkg::RK_NONE);
        add_row(7'd53, 64'hA5A5_A5A5_A5A5_A5A5, 7'd100, -300, 0, '0, 0,
                mrne_pkg::RK_NONE);
        // zero target acts as a one-bit target
        add_row(7'd0, 64'hC000_0000_0000_0000, 7'd2, 7, 1,
                64'h8000_0000_0000_0000, 8, mrne_pkg::RK_UP);
        add_row(7'd0, 64'h4000_0000_0000_0000, 7'd64, 7, 1, 64'd0, 7,
                mrne_pkg::RK_DOWN);
        add_row(7'd0, 64'h8000_0000_0000_0000, 7'd1, 9, 1,
                64'h8000_0000_0000_0000, 9, mrne_pkg::RK_NONE);
        add_row(7'd0, 64'hDEAD_BEEF_0BAD_F00D, 7'd64, 0, 0, '0, 0, mrne_pkg::RK_NONE);
        // full-width target never rounds
        add_row(7'd64, ~64'd0, 7'd64, -32768, 1, ~64'd0, -32768, mrne_pkg::RK_NONE);
        add_row(7'd64, ~64'd0, 7'd127, 32767, 1, ~64'd0, 32767, mrne_pkg::RK_NONE);
        add_row(7'd64, 64'h5555_5555_5555_5555, 7'd33, 77, 0, '0, 0, mrne_pkg::RK_NONE);
        add_row(7'd1, 64'h8000_0000_0000_0001, 7'd64, 0, 1,
                64'h8000_0000_0000_0000, 0, mrne_pkg::RK_DOWN);
        add_row(7'd1, ~64'd0, 7'd64, 32767, 1, 64'h8000_0000_0000_0000, 32767,
                mrne_pkg::RK_UP);
        // target above 64 saturates
        add_row(7'd127, 64'h1234_5678_9ABC_DEF0, 7'd64, -5, 0, '0, 0, mrne_pkg::RK_NONE);
        add_row(7'd127, 64'hFEDC_BA98_7654_3210, 7'd70, 12, 0, '0, 0, mrne_pkg::RK_NONE);

        phase_tgt = '{7'd53, 7'd1, 7'd64, 7'd0, 7'd127, 7'd24, 7'd63, 7'd65,
                      7'($urandom_range(0, 127)), 7'($urandom_range(1, 64))};

        // reset: asserted at the start, once
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: rewrite the target whenever a row asks for another one
        foreach (dir_rows[i]) begin
            if (dir_rows[i].tgt != cur_tgt)
                set_target(dir_rows[i].tgt);
            if (dir_rows[i].known)
                want = dir_rows[i].want;
            else
                want = round_nearest_even(dir_rows[i].mant, dir_rows[i].len,
                                          dir_rows[i].exp, cur_tgt);
            send_item(dir_rows[i].mant, dir_rows[i].len, dir_rows[i].exp, want);
        end

        // random part, one target length per phase
        for (int p = 0; p < N_PHASES; p++) begin
            set_target(phase_tgt[p]);
            calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) begin
                make_item(mant, len, exp);
                send_item(mant, len, exp, round_nearest_even(mant, len, exp, cur_tgt));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        $display("%0d numbers rounded, %0d results checked, %0d target length writes",
                 items_sent, results_seen, cfg_writes);
        $display("targets covered: zero, one, full width, above 64 and mid values");
        if (errors == 0)
            $display("mantissa_round_nearest_even_tb: done, clean");
        else
            $display("mantissa_round_nearest_even_tb: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/mrne_pkg.sv
rtl/mrne_mask.sv
rtl/mrne_decide.sv
rtl/mrne_incr.sv
rtl/mantissa_round_nearest_even.sv
tb/sv/mantissa_round_nearest_even_tb.sv
